FILE: sv/rbb_pkg.sv
package rbb_pkg;

   localparam int unsigned SINE_DEPTH_DEFAULT = 1024;

   localparam longint unsigned POLY_A1 = 64'd1686629713;
   localparam longint unsigned POLY_A3 = 64'd693598668;
   localparam longint unsigned POLY_A5 = 64'd85569306;
   localparam longint unsigned POLY_A7 = 64'd5026995;
   localparam longint unsigned POLY_A9 = 64'd172272;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 15;

   localparam logic [14:0] BOX_WIDTH_RESET    = 15'd320;
   localparam logic [14:0] BOX_HEIGHT_RESET   = 15'd320;
   localparam logic [11:0] SPIN_RATE_RESET    = 12'd0;
   localparam logic [10:0] FIELD_WIDTH_RESET  = 11'd800;
   localparam logic [10:0] FIELD_HEIGHT_RESET = 11'd600;

   localparam logic [11:0] QUARTER_TURN = 12'd1024;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BOX_WIDTH    = 3'd0,
      CSR_BOX_HEIGHT   = 3'd1,
      CSR_SPIN_RATE    = 3'd2,
      CSR_FIELD_WIDTH  = 3'd3,
      CSR_FIELD_HEIGHT = 3'd4
   } csr_index_type;

   typedef enum logic {
      ACT_TICK  = 1'b0,
      ACT_PLACE = 1'b1
   } action_type;

   typedef struct packed {
      logic signed [15:0] pos;
      logic signed [10:0] vel;
      logic               flip;
   } axis_type;

endpackage

FILE: sv/rbb_sine.sv
module rbb_sine #(
   parameter int unsigned SINE_TABLE_DEPTH = rbb_pkg::SINE_DEPTH_DEFAULT
) (
   input  logic [11:0]        angle,
   output logic signed [16:0] value
);

   localparam int unsigned IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int unsigned SCALE_W = IDX_W + 10;

   typedef logic [15:0] rom_type [SINE_TABLE_DEPTH+1];

   function automatic rom_type build_rom();
      rom_type         r;
      longint unsigned t;
      longint unsigned t2;
      longint unsigned s;
      longint unsigned v;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         t  = (longint'(k) << 30) / SINE_TABLE_DEPTH;
         t2 = (t * t) >> 30;
         s  = rbb_pkg::POLY_A9;
         s  = rbb_pkg::POLY_A7 - ((s * t2) >> 30);
         s  = rbb_pkg::POLY_A5 - ((s * t2) >> 30);
         s  = rbb_pkg::POLY_A3 - ((s * t2) >> 30);
         s  = rbb_pkg::POLY_A1 - ((s * t2) >> 30);
         v  = (((s * t) >> 30) + 64'd16384) >> 15;
         r[k] = (v > 64'd32768) ? 16'd32768 : v[15:0];
      end
      return r;
   endfunction

   localparam rom_type ROM = build_rom();

   logic [SCALE_W-1:0] scaled;
   logic [IDX_W-1:0]   k;
   logic [IDX_W-1:0]   idx;
   logic [15:0]        mag;

   always_comb begin
      scaled = SCALE_W'(angle[9:0]) * SCALE_W'(SINE_TABLE_DEPTH);
      k      = scaled[SCALE_W-1:10];
      idx    = angle[10] ? (IDX_W'(SINE_TABLE_DEPTH) - k) : k;
      mag    = ROM[idx];
      value  = angle[11] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

endmodule

FILE: sv/rbb_geom.sv
module rbb_geom (
   input  logic signed [15:0] center_x,
   input  logic signed [15:0] center_y,
   input  logic signed [16:0] sin_val,
   input  logic signed [16:0] cos_val,
   input  logic [14:0]        box_width,
   input  logic [14:0]        box_height,
   output logic [3:0][15:0]   corner_x,
   output logic [3:0][15:0]   corner_y,
   output logic [16:0]        ext_x,
   output logic [16:0]        ext_y
);

   function automatic logic [15:0] round_sat(input logic signed [34:0] v);
      logic signed [34:0] r;
      logic signed [18:0] q;
      r = v + 35'sd32768;
      q = r[34:16];
      if (q > 19'sd32767) begin
         return 16'h7FFF;
      end else if (q < -19'sd32768) begin
         return 16'h8000;
      end
      return q[15:0];
   endfunction

   function automatic logic [31:0] mag(input logic signed [32:0] v);
      logic signed [32:0] a;
      a = v[32] ? -v : v;
      return a[31:0];
   endfunction

   logic signed [32:0] hwc;
   logic signed [32:0] hws;
   logic signed [32:0] hhc;
   logic signed [32:0] hhs;
   logic signed [34:0] cx;
   logic signed [34:0] cy;
   logic [33:0]        sum_x;
   logic [33:0]        sum_y;

   always_comb begin
      hwc = $signed({1'b0, box_width})  * cos_val;
      hws = $signed({1'b0, box_width})  * sin_val;
      hhc = $signed({1'b0, box_height}) * cos_val;
      hhs = $signed({1'b0, box_height}) * sin_val;
      cx  = 35'($signed({center_x, 16'h0000}));
      cy  = 35'($signed({center_y, 16'h0000}));

      corner_x[0] = round_sat(cx - 35'(hwc) + 35'(hhs));
      corner_y[0] = round_sat(cy - 35'(hws) - 35'(hhc));
      corner_x[1] = round_sat(cx + 35'(hwc) + 35'(hhs));
      corner_y[1] = round_sat(cy + 35'(hws) - 35'(hhc));
      corner_x[2] = round_sat(cx + 35'(hwc) - 35'(hhs));
      corner_y[2] = round_sat(cy + 35'(hws) + 35'(hhc));
      corner_x[3] = round_sat(cx - 35'(hwc) - 35'(hhs));
      corner_y[3] = round_sat(cy - 35'(hws) + 35'(hhc));

      sum_x = 34'(mag(hwc)) + 34'(mag(hhs)) + 34'd32768;
      sum_y = 34'(mag(hws)) + 34'(mag(hhc)) + 34'd32768;
      ext_x = sum_x[32:16];
      ext_y = sum_y[32:16];
   end

endmodule

FILE: sv/rbb_axis.sv
module rbb_axis (
   input  logic signed [15:0] pos,
   input  logic signed [10:0] vel,
   input  logic [16:0]        ext,
   input  logic [10:0]        pixels,
   output rbb_pkg::axis_type  res
);

   logic signed [19:0] p;
   logic signed [19:0] e;
   logic signed [19:0] f;
   logic signed [19:0] p_new;
   logic               in_field;

   always_comb begin
      p        = 20'(pos);
      e        = $signed({3'b000, ext});
      f        = $signed({5'b00000, pixels, 4'b0000});
      in_field = ((p - e) >= 20'sd0) && ((p + e) <= f);
      priority if ((e <<< 1) > f) begin
         p_new = f >>> 1;
      end else if (p < e) begin
         p_new = e;
      end else if (p > (f - e)) begin
         p_new = f - e;
      end else begin
         p_new = p;
      end
      if (in_field) begin
         res.pos  = pos;
         res.vel  = vel;
         res.flip = 1'b0;
      end else begin
         res.pos  = p_new[15:0];
         res.vel  = (vel == -11'sd1024) ? 11'sd1023 : -vel;
         res.flip = 1'b1;
      end
   end

endmodule

FILE: sv/rotated_box_bounce_step_top.sv
// Rotated box bounce stepper. A place beat loads centre and velocity and zeroes the angle; it
// yields no response. A tick beat moves the box, turns it by spin_rate, and yields one response
// with the four corners (before clamping), the clamped centre, heading and bounce flags. One
// beat is taken every cycle unless a tick beat waits on a stalled response; a tick response
// passes the input register and then the result register, the only stages. The state feedback
// path (centre add, sine table lookup, box multiply, round and clamp) sets the clock limit. The
// sine table is a quarter wave of SINE_TABLE_DEPTH+1 constant entries built at elaboration.
module rotated_box_bounce_step_top #(
   parameter int unsigned SINE_TABLE_DEPTH = rbb_pkg::SINE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_action,
   input  logic [14:0]                        req_place_x,
   input  logic [14:0]                        req_place_y,
   input  logic signed [10:0]                 req_place_speed_x,
   input  logic signed [10:0]                 req_place_speed_y,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [15:0]                 rsp_corner0_x,
   output logic signed [15:0]                 rsp_corner0_y,
   output logic signed [15:0]                 rsp_corner1_x,
   output logic signed [15:0]                 rsp_corner1_y,
   output logic signed [15:0]                 rsp_corner2_x,
   output logic signed [15:0]                 rsp_corner2_y,
   output logic signed [15:0]                 rsp_corner3_x,
   output logic signed [15:0]                 rsp_corner3_y,
   output logic signed [15:0]                 rsp_center_out_x,
   output logic signed [15:0]                 rsp_center_out_y,
   output logic [11:0]                        rsp_heading,
   output logic [1:0]                         rsp_bounce_flags,
   input  logic                               csr_write_en,
   input  logic [rbb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rbb_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [14:0]        box_width_ff;
   logic [14:0]        box_height_ff;
   logic [11:0]        spin_rate_ff;
   logic [10:0]        field_width_ff;
   logic [10:0]        field_height_ff;

   logic               in_vld_ff;
   rbb_pkg::action_type in_action_ff;
   logic [14:0]        in_place_x_ff;
   logic [14:0]        in_place_y_ff;
   logic signed [10:0] in_speed_x_ff;
   logic signed [10:0] in_speed_y_ff;

   logic signed [15:0] center_x_ff;
   logic signed [15:0] center_y_ff;
   logic signed [10:0] velocity_x_ff;
   logic signed [10:0] velocity_y_ff;
   logic [11:0]        rotation_ff;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [3:0][15:0]   corner_x_ff;
   logic [3:0][15:0]   corner_y_ff;
   logic signed [15:0] center_out_x_ff;
   logic signed [15:0] center_out_y_ff;
   logic [11:0]        heading_ff;
   logic [1:0]         flags_ff;

   logic               in_vld_in;
   logic               out_ready;
   logic               consume;
   logic               tick_go;
   logic               take_req;
   logic signed [15:0] moved_x;
   logic signed [15:0] moved_y;
   logic [11:0]        rotation_in;
   logic signed [16:0] sin_val;
   logic signed [16:0] cos_val;
   logic [3:0][15:0]   corner_x;
   logic [3:0][15:0]   corner_y;
   logic [16:0]        ext_x;
   logic [16:0]        ext_y;
   rbb_pkg::axis_type  axis_x;
   rbb_pkg::axis_type  axis_y;

   function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                  input logic signed [10:0] b);
      logic signed [16:0] s;
      s = 17'(a) + 17'(b);
      if (s > 17'sd32767) begin
         return 16'sh7FFF;
      end else if (s < -17'sd32768) begin
         return -16'sd32768;
      end
      return s[15:0];
   endfunction

   always_comb begin
      out_ready   = !rsp_valid_ff || !rsp_stall;
      consume     = in_vld_ff && ((in_action_ff == rbb_pkg::ACT_PLACE) || out_ready);
      tick_go     = consume && (in_action_ff == rbb_pkg::ACT_TICK);
      req_stall   = in_vld_ff && !consume;
      take_req    = req_valid && !req_stall;
      in_vld_in   = take_req || (in_vld_ff && !consume);
      rsp_valid_in = tick_go || (rsp_valid_ff && !out_ready);
      moved_x     = sat_add(center_x_ff, velocity_x_ff);
      moved_y     = sat_add(center_y_ff, velocity_y_ff);
      rotation_in = rotation_ff + spin_rate_ff;
   end

   rbb_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sin (
      .angle (rotation_in),
      .value (sin_val)
   );

   rbb_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_cos (
      .angle (rotation_in + rbb_pkg::QUARTER_TURN),
      .value (cos_val)
   );

   rbb_geom u_geom (
      .center_x   (moved_x),
      .center_y   (moved_y),
      .sin_val    (sin_val),
      .cos_val    (cos_val),
      .box_width  (box_width_ff),
      .box_height (box_height_ff),
      .corner_x   (corner_x),
      .corner_y   (corner_y),
      .ext_x      (ext_x),
      .ext_y      (ext_y)
   );

   rbb_axis u_axis_x (
      .pos    (moved_x),
      .vel    (velocity_x_ff),
      .ext    (ext_x),
      .pixels (field_width_ff),
      .res    (axis_x)
   );

   rbb_axis u_axis_y (
      .pos    (moved_y),
      .vel    (velocity_y_ff),
      .ext    (ext_y),
      .pixels (field_height_ff),
      .res    (axis_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         box_width_ff    <= rbb_pkg::BOX_WIDTH_RESET;
         box_height_ff   <= rbb_pkg::BOX_HEIGHT_RESET;
         spin_rate_ff    <= rbb_pkg::SPIN_RATE_RESET;
         field_width_ff  <= rbb_pkg::FIELD_WIDTH_RESET;
         field_height_ff <= rbb_pkg::FIELD_HEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (rbb_pkg::csr_index_type'(csr_index))
            rbb_pkg::CSR_BOX_WIDTH:    box_width_ff    <= csr_wdata;
            rbb_pkg::CSR_BOX_HEIGHT:   box_height_ff   <= csr_wdata;
            rbb_pkg::CSR_SPIN_RATE:    spin_rate_ff    <= csr_wdata[11:0];
            rbb_pkg::CSR_FIELD_WIDTH:  field_width_ff  <= csr_wdata[10:0];
            rbb_pkg::CSR_FIELD_HEIGHT: field_height_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_action_ff  <= rbb_pkg::action_type'(req_action);
         in_place_x_ff <= req_place_x;
         in_place_y_ff <= req_place_y;
         in_speed_x_ff <= req_place_speed_x;
         in_speed_y_ff <= req_place_speed_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         velocity_x_ff <= '0;
         velocity_y_ff <= '0;
         rotation_ff   <= '0;
      end else if (consume) begin
         if (in_action_ff == rbb_pkg::ACT_PLACE) begin
            center_x_ff   <= $signed({1'b0, in_place_x_ff});
            center_y_ff   <= $signed({1'b0, in_place_y_ff});
            velocity_x_ff <= in_speed_x_ff;
            velocity_y_ff <= in_speed_y_ff;
            rotation_ff   <= '0;
         end else begin
            center_x_ff   <= axis_x.pos;
            center_y_ff   <= axis_y.pos;
            velocity_x_ff <= axis_x.vel;
            velocity_y_ff <= axis_y.vel;
            rotation_ff   <= rotation_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_go) begin
         corner_x_ff     <= corner_x;
         corner_y_ff     <= corner_y;
         center_out_x_ff <= axis_x.pos;
         center_out_y_ff <= axis_y.pos;
         heading_ff      <= rotation_in;
         flags_ff        <= {axis_y.flip, axis_x.flip};
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_corner0_x    = corner_x_ff[0];
   assign rsp_corner0_y    = corner_y_ff[0];
   assign rsp_corner1_x    = corner_x_ff[1];
   assign rsp_corner1_y    = corner_y_ff[1];
   assign rsp_corner2_x    = corner_x_ff[2];
   assign rsp_corner2_y    = corner_y_ff[2];
   assign rsp_corner3_x    = corner_x_ff[3];
   assign rsp_corner3_y    = corner_y_ff[3];
   assign rsp_center_out_x = center_out_x_ff;
   assign rsp_center_out_y = center_out_y_ff;
   assign rsp_heading      = heading_ff;
   assign rsp_bounce_flags = flags_ff;

endmodule

FILE: sv/rbb_checker.sv
module rbb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            req_action,
   input logic [14:0]                     req_place_x,
   input logic [14:0]                     req_place_y,
   input logic signed [10:0]              req_place_speed_x,
   input logic signed [10:0]              req_place_speed_y,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic signed [15:0]              rsp_corner0_x,
   input logic signed [15:0]              rsp_corner0_y,
   input logic signed [15:0]              rsp_corner1_x,
   input logic signed [15:0]              rsp_corner1_y,
   input logic signed [15:0]              rsp_corner2_x,
   input logic signed [15:0]              rsp_corner2_y,
   input logic signed [15:0]              rsp_corner3_x,
   input logic signed [15:0]              rsp_corner3_y,
   input logic signed [15:0]              rsp_center_out_x,
   input logic signed [15:0]              rsp_center_out_y,
   input logic [11:0]                     rsp_heading,
   input logic [1:0]                      rsp_bounce_flags,
   input logic                            csr_write_en,
   input logic [rbb_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [rbb_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_drain_no_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |-> !req_stall)
      else $error("request stalled while result drains");

   a_clamp_x: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bounce_flags[0]) |-> !rsp_center_out_x[15])
      else $error("clamped x centre negative");

   a_clamp_y: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bounce_flags[1]) |-> !rsp_center_out_y[15])
      else $error("clamped y centre negative");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_heading)
         && $stable(rsp_center_out_x) && $stable(rsp_corner0_x)))
      else $error("stalled response beat changed");

endmodule

bind rotated_box_bounce_step_top rbb_checker u_rbb_checker (.*);
